// ===== hdl/vfe_pkg.sv =====
// ============================================================================
// vfe_pkg
// Shared types and constants for the VXLAN frame encapsulator.
// ============================================================================
`default_nettype none

package vfe_pkg;

    localparam int INNER_BYTES = 14;
    localparam int HDR_BYTES   = 50;
    localparam int POS_W       = 4;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int SUM_W       = 19;

    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(INNER_BYTES - 1);
    localparam logic [POS_W-1:0] SMAC_FIRST    = 4'd6;
    localparam logic [POS_W-1:0] SMAC_LAST     = 4'd11;
    localparam logic [IDX_W-1:0] HDR_IDX_LAST  = IDX_W'(HDR_BYTES - 1);

    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  IP_TTL         = 8'h40;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
    localparam logic [15:0] IP_LEN_ADD     = 16'd36;
    localparam logic [15:0] UDP_LEN_ADD    = 16'd16;
    localparam logic [7:0]  VXLAN_FLAGS    = 8'h08;
    localparam logic [15:0] UDP_PORT_RESET = 16'd4789;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_MAC  = 3'd0,
        REG_DST_MAC  = 3'd1,
        REG_SRC_IP   = 3'd2,
        REG_DST_IP   = 3'd3,
        REG_UDP_PORT = 3'd4,
        REG_NET_ID   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic buf_write;
        logic calc_sum;
        logic calc_fold;
        logic hdr_load;
        logic held_load;
        logic pass_load;
    } cmd_t;

    typedef struct packed {
        logic hdr_full;
        logic out_room;
        logic hdr_last;
        logic held_last;
        logic end_flag;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/vfe_ctrl.sv =====
// ============================================================================
// vfe_ctrl
// Frame sequencer: collect inner header, checksum, emit outer header, held
// bytes, then pass the rest of the frame, if any.
// ============================================================================
`default_nettype none

module vfe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          frame_end,
    input  wire vfe_pkg::sts_t sts,
    output vfe_pkg::cmd_t      cmd,
    output logic               in_stall
);
    import vfe_pkg::*;

    typedef enum logic [5:0] {
        S_COLLECT = 6'b000001,
        S_SUM     = 6'b000010,
        S_FOLD    = 6'b000100,
        S_HEAD    = 6'b001000,
        S_HELD    = 6'b010000,
        S_PASS    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.buf_write = 1'b1;
                    if (sts.hdr_full || frame_end)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.calc_fold = 1'b1;
                state_next    = S_HEAD;
            end
            S_HEAD:
            begin
                if (sts.out_room)
                begin
                    cmd.hdr_load = 1'b1;
                    if (sts.hdr_last)
                    begin
                        state_next = S_HELD;
                    end
                end
            end
            S_HELD:
            begin
                if (sts.out_room)
                begin
                    cmd.held_load = 1'b1;
                    if (sts.held_last)
                    begin
                        state_next = sts.end_flag ? S_COLLECT : S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                in_stall = !sts.out_room;
                if (in_valid && sts.out_room)
                begin
                    cmd.pass_load = 1'b1;
                    if (frame_end)
                    begin
                        state_next = S_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vfe_datapath.sv =====
// ============================================================================
// vfe_datapath
// Configuration registers, inner header buffer, checksums, direction match,
// header byte select and output word register.
// ============================================================================
`default_nettype none

module vfe_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [vfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [7:0]                      frame_byte,
    input  wire logic [15:0]                     frame_length,
    input  wire logic                            frame_end,
    input  wire vfe_pkg::cmd_t                   cmd,
    output vfe_pkg::sts_t                        sts,
    output logic [7:0]                           out_byte,
    output logic                                 out_last,
    output logic                                 out_valid,
    input  wire logic                            out_stall
);
    import vfe_pkg::*;

    function automatic logic [15:0] ones_fold(input logic [SUM_W-1:0] s);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, s[15:0]} + {14'b0, s[SUM_W-1:16]};
        s2 = s1[15:0] + {15'b0, s1[16]};
        return ~s2;
    endfunction

    logic [47:0]       src_mac_reg;
    logic [47:0]       dst_mac_reg;
    logic [31:0]       src_ip_reg;
    logic [31:0]       dst_ip_reg;
    logic [15:0]       udp_port_reg;
    logic [23:0]       net_id_reg;

    logic [7:0]        head_buf_reg [INNER_BYTES];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic              end_reg;
    logic              end_next;
    logic [15:0]       len_reg;
    logic [15:0]       len_next;
    logic [SUM_W-1:0]  isum_reg;
    logic [SUM_W-1:0]  isum_next;
    logic [47:0]       smac_reg;
    logic [47:0]       smac_next;
    logic [47:0]       first_mac_reg;
    logic              first_seen_reg;
    logic              swap_reg;
    logic [SUM_W-1:0]  ipsum_reg;
    logic [15:0]       ip_csum_reg;
    logic [15:0]       sport_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [SUM_W-1:0]  word_add;
    logic [2:0]        smac_slot;
    logic [5:0]        smac_base;
    logic [15:0]       ip_len;
    logic [15:0]       udp_len;
    logic [47:0]       mac_d;
    logic [47:0]       mac_s;
    logic [31:0]       ip_s;
    logic [31:0]       ip_d;
    logic [HDR_BYTES*8-1:0] hdr_vec;
    logic [8:0]        hdr_pos;
    logic [7:0]        hdr_byte;
    logic [SUM_W-1:0]  ipsum_calc;
    logic              any_load;

    assign ip_len  = len_reg + IP_LEN_ADD;
    assign udp_len = len_reg + UDP_LEN_ADD;
    assign mac_d   = swap_reg ? src_mac_reg : dst_mac_reg;
    assign mac_s   = swap_reg ? dst_mac_reg : src_mac_reg;
    assign ip_s    = swap_reg ? dst_ip_reg  : src_ip_reg;
    assign ip_d    = swap_reg ? src_ip_reg  : dst_ip_reg;

    assign ipsum_calc = SUM_W'({IP_VER_IHL, 8'h00}) + SUM_W'(ip_len)
                      + SUM_W'(IP_FLAGS_DF) + SUM_W'({IP_TTL, IP_PROTO_UDP})
                      + SUM_W'(src_ip_reg[31:16]) + SUM_W'(src_ip_reg[15:0])
                      + SUM_W'(dst_ip_reg[31:16]) + SUM_W'(dst_ip_reg[15:0]);

    assign hdr_vec = {mac_d, mac_s, ETH_TYPE_IPV4, IP_VER_IHL, 8'h00, ip_len,
                      16'h0000, IP_FLAGS_DF, IP_TTL, IP_PROTO_UDP, ip_csum_reg,
                      ip_s, ip_d, sport_reg[7:0], sport_reg[15:8], udp_port_reg,
                      udp_len, 16'h0000, VXLAN_FLAGS, 24'h000000, net_id_reg,
                      8'h00};
    assign hdr_pos  = 9'(HDR_BYTES * 8 - 8) - {idx_reg, 3'b000};
    assign hdr_byte = hdr_vec[hdr_pos +: 8];

    assign any_load = cmd.hdr_load || cmd.held_load || cmd.pass_load;

    assign sts.hdr_full  = (pos_reg == POS_LAST);
    assign sts.out_room  = !out_valid_reg || !out_stall;
    assign sts.hdr_last  = (idx_reg == HDR_IDX_LAST);
    assign sts.held_last = (idx_reg[POS_W-1:0] == count_reg - 4'd1);
    assign sts.end_flag  = end_reg;

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        end_next   = end_reg;
        len_next   = len_reg;
        isum_next  = isum_reg;
        smac_next  = smac_reg;
        idx_next   = idx_reg;
        word_add   = pos_reg[0] ? SUM_W'(frame_byte) : SUM_W'({frame_byte, 8'h00});
        smac_slot  = 3'(pos_reg - SMAC_FIRST);
        smac_base  = 6'd40 - {smac_slot, 3'b000};

        if (cmd.buf_write)
        begin
            if (pos_reg == '0)
            begin
                isum_next = word_add;
                smac_next = '0;
            end
            else
            begin
                isum_next = isum_reg + word_add;
            end
            if (pos_reg >= SMAC_FIRST && pos_reg <= SMAC_LAST)
            begin
                smac_next[smac_base +: 8] = frame_byte;
            end
            if (pos_reg == POS_LAST || frame_end)
            begin
                pos_next   = '0;
                count_next = pos_reg + 4'd1;
                end_next   = frame_end;
                len_next   = frame_length;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end

        if (cmd.calc_fold)
        begin
            idx_next = '0;
        end
        else if (cmd.hdr_load)
        begin
            idx_next = (idx_reg == HDR_IDX_LAST) ? '0 : idx_reg + 6'd1;
        end
        else if (cmd.held_load)
        begin
            idx_next = idx_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_mac_reg    <= '0;
            dst_mac_reg    <= '0;
            src_ip_reg     <= '0;
            dst_ip_reg     <= '0;
            udp_port_reg   <= UDP_PORT_RESET;
            net_id_reg     <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            end_reg        <= 1'b0;
            idx_reg        <= '0;
            first_seen_reg <= 1'b0;
            first_mac_reg  <= '0;
            swap_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SRC_MAC:  src_mac_reg  <= cfg_data;
                    REG_DST_MAC:  dst_mac_reg  <= cfg_data;
                    REG_SRC_IP:   src_ip_reg   <= cfg_data[31:0];
                    REG_DST_IP:   dst_ip_reg   <= cfg_data[31:0];
                    REG_UDP_PORT: udp_port_reg <= cfg_data[15:0];
                    REG_NET_ID:   net_id_reg   <= cfg_data[23:0];
                    default:      ;
                endcase
            end

            pos_reg   <= pos_next;
            count_reg <= count_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;

            if (cmd.calc_sum)
            begin
                if (!first_seen_reg)
                begin
                    first_seen_reg <= 1'b1;
                    first_mac_reg  <= smac_reg;
                    swap_reg       <= 1'b0;
                end
                else
                begin
                    swap_reg <= (smac_reg != first_mac_reg);
                end
            end

            if (any_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        isum_reg <= isum_next;
        smac_reg <= smac_next;
        if (cmd.buf_write)
        begin
            head_buf_reg[pos_reg] <= frame_byte;
        end
        if (cmd.calc_sum)
        begin
            ipsum_reg <= ipsum_calc;
        end
        if (cmd.calc_fold)
        begin
            ip_csum_reg <= ones_fold(ipsum_reg);
            sport_reg   <= ones_fold(isum_reg);
        end
        if (cmd.hdr_load)
        begin
            out_byte_reg <= hdr_byte;
            out_last_reg <= 1'b0;
        end
        else if (cmd.held_load)
        begin
            out_byte_reg <= head_buf_reg[idx_reg[POS_W-1:0]];
            out_last_reg <= end_reg && (idx_reg[POS_W-1:0] == count_reg - 4'd1);
        end
        else if (cmd.pass_load)
        begin
            out_byte_reg <= frame_byte;
            out_last_reg <= frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vxlan_frame_encapsulator_unit.sv =====
// ============================================================================
// vxlan_frame_encapsulator_unit
// VXLAN over IPv4 encapsulator: prepends a 50-byte outer header to each
// inner Ethernet frame.
// ============================================================================
// The first 14 inner bytes (or fewer, on a short frame) are taken one word per
// cycle into a header buffer while the inner-header checksum and source MAC
// build up. The sequencer then forms the IP and UDP-port checksums and the
// direction match in its sum and fold states, sends the 50 header words and
// the held bytes at one word per cycle when the output is not stalled, and
// then passes the rest of the frame one word per cycle, also only while the
// output is not stalled. Input is stalled from the last buffered byte until
// the held bytes are sent. The config port never stalls.
`default_nettype none

module vxlan_frame_encapsulator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [vfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      frame_byte,
    input  wire logic [15:0]                     frame_length,
    input  wire logic                            frame_end,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           out_byte,
    output logic                                 out_last
);
    import vfe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    vfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    vfe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_byte   (frame_byte),
        .frame_length (frame_length),
        .frame_end    (frame_end),
        .cmd          (cmd),
        .sts          (sts),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

`default_nettype wire

// ===== tb/vfe_encap_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vfe_encap_checker
// Watches the config, inner-frame and outer-frame channels of the VXLAN
// encapsulator. Builds the expected 50-byte outer header for each inner frame
// plus its frame bytes, and compares each outer word as it is accepted.
// ============================================================================

module vfe_encap_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [vfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [7:0]                      frame_byte,
    input  wire logic [15:0]                     frame_length,
    input  wire logic                            frame_end,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [7:0]                      out_byte,
    input  wire logic                            out_last,
    output int                                   miscompares,
    output int                                   words_owed
);
    import vfe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } enc_word_t;

    enc_word_t   owed_words[$];

    logic [47:0] src_mac_r;
    logic [47:0] dst_mac_r;
    logic [31:0] src_ip_r;
    logic [31:0] dst_ip_r;
    logic [15:0] dport_r;
    logic [23:0] vni_r;

    logic [7:0]  head_q [INNER_BYTES];
    int          fill;
    logic [47:0] home_smac;
    logic        home_known;

    function automatic logic [15:0] ones_sum16(input logic [31:0] acc);
        acc = acc[15:0] + acc[31:16];
        acc = acc[15:0] + acc[31:16];
        return ~acc[15:0];
    endfunction

    task automatic push_word(input logic [7:0] b, input logic fin);
        enc_word_t w;
        w.data = b;
        w.fin  = fin;
        owed_words.push_back(w);
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
        case (idx)
            REG_SRC_MAC:  src_mac_r = v;
            REG_DST_MAC:  dst_mac_r = v;
            REG_SRC_IP:   src_ip_r  = v[31:0];
            REG_DST_IP:   dst_ip_r  = v[31:0];
            REG_UDP_PORT: dport_r   = v[15:0];
            REG_NET_ID:   vni_r     = v[23:0];
            default: ;
        endcase
    endtask

    task automatic push_outer_header(input int cnt, input logic [15:0] len, input logic fin);
        logic [7:0]  hdr [HDR_BYTES];
        logic [7:0]  seen [INNER_BYTES];
        logic [47:0] smac;
        logic [47:0] mac_d;
        logic [47:0] mac_s;
        logic [31:0] ip_s;
        logic [31:0] ip_d;
        logic [31:0] acc;
        logic [15:0] sport;
        logic [15:0] ipsum;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        int          i;

        for (i = 0; i < INNER_BYTES; i++)
            seen[i] = (i < cnt) ? head_q[i] : 8'h00;
        smac = '0;
        for (i = SMAC_FIRST; i <= SMAC_LAST; i++)
            smac = {smac[39:0], seen[i]};
        if (!home_known)
        begin
            home_smac  = smac;
            home_known = 1'b1;
        end
        if (smac == home_smac)
        begin
            mac_d = dst_mac_r;
            mac_s = src_mac_r;
            ip_s  = src_ip_r;
            ip_d  = dst_ip_r;
        end
        else
        begin
            mac_d = src_mac_r;
            mac_s = dst_mac_r;
            ip_s  = dst_ip_r;
            ip_d  = src_ip_r;
        end

        acc = '0;
        for (i = 0; i < INNER_BYTES / 2; i++)
            acc = acc + {seen[2 * i], seen[2 * i + 1]};
        sport   = ones_sum16(acc);
        ip_len  = len + IP_LEN_ADD;
        udp_len = len + UDP_LEN_ADD;

        for (i = 0; i < HDR_BYTES; i++)
            hdr[i] = 8'h00;
        for (i = 0; i < 6; i++)
        begin
            hdr[i]     = mac_d[47 - 8 * i -: 8];
            hdr[6 + i] = mac_s[47 - 8 * i -: 8];
        end
        hdr[12] = ETH_TYPE_IPV4[15:8];
        hdr[13] = ETH_TYPE_IPV4[7:0];
        hdr[14] = IP_VER_IHL;
        hdr[16] = ip_len[15:8];
        hdr[17] = ip_len[7:0];
        hdr[20] = IP_FLAGS_DF[15:8];
        hdr[21] = IP_FLAGS_DF[7:0];
        hdr[22] = IP_TTL;
        hdr[23] = IP_PROTO_UDP;
        for (i = 0; i < 4; i++)
        begin
            hdr[26 + i] = ip_s[31 - 8 * i -: 8];
            hdr[30 + i] = ip_d[31 - 8 * i -: 8];
        end
        acc = '0;
        for (i = 0; i < 10; i++)
            acc = acc + {hdr[14 + 2 * i], hdr[15 + 2 * i]};
        ipsum   = ones_sum16(acc);
        hdr[24] = ipsum[15:8];
        hdr[25] = ipsum[7:0];
        // source port goes out low byte first
        hdr[34] = sport[7:0];
        hdr[35] = sport[15:8];
        hdr[36] = dport_r[15:8];
        hdr[37] = dport_r[7:0];
        hdr[38] = udp_len[15:8];
        hdr[39] = udp_len[7:0];
        hdr[42] = VXLAN_FLAGS;
        hdr[46] = vni_r[23:16];
        hdr[47] = vni_r[15:8];
        hdr[48] = vni_r[7:0];

        for (i = 0; i < HDR_BYTES; i++)
            push_word(hdr[i], 1'b0);
        for (i = 0; i < cnt; i++)
            push_word(head_q[i], (i == cnt - 1) ? fin : 1'b0);
    endtask

    task automatic take_inner_word(input logic [7:0] b, input logic [15:0] len, input logic fin);
        if (fill < INNER_BYTES)
        begin
            head_q[fill] = b;
            fill++;
            if (fill == INNER_BYTES || fin)
            begin
                push_outer_header(fill, len, fin);
                fill = fin ? 0 : INNER_BYTES;
            end
        end
        else
        begin
            push_word(b, fin);
            if (fin)
                fill = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_word_t want;
        if (!rst_n)
        begin
            owed_words.delete();
            src_mac_r   = '0;
            dst_mac_r   = '0;
            src_ip_r    = '0;
            dst_ip_r    = '0;
            dport_r     = UDP_PORT_RESET;
            vni_r       = '0;
            for (int i = 0; i < INNER_BYTES; i++)
                head_q[i] = 8'h00;
            fill        = 0;
            home_smac   = '0;
            home_known  = 1'b0;
            miscompares = 0;
            words_owed  = 0;
        end
        else
        begin
            // compare before predicting: no word can leave on the edge it enters
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $display("%0t: unexpected word out_byte=%h out_last=%b",
                             $time, out_byte, out_last);
                    miscompares++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.data, out_byte);
                        miscompares++;
                    end
                    if (out_last !== want.fin)
                    begin
                        $display("%0t: out_last expected %b actual %b",
                                 $time, want.fin, out_last);
                        miscompares++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                take_inner_word(frame_byte, frame_length, frame_end);
            words_owed = owed_words.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus for the VXLAN encapsulator: directed frames at the field extremes,
// short frames and both traffic directions, then random frames under several
// register settings with random gaps and output stalls. The checker beside
// the block does all comparison; this module reports the verdict.
// ============================================================================

module tb;
    import vfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int CFG_ZEROS    = 0;
    localparam int CFG_ONES     = 1;
    localparam int CFG_RANDOM   = 2;
    localparam int MAX_FRAME    = 64;
    localparam int RANDOM_WORDS = 96;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            frame_byte;
    logic [15:0]           frame_length;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_byte;
    logic                  out_last;
    int                    miscompares;
    int                    words_owed;
    int                    cycle_count = 0;

    logic [7:0]            frame_buf [MAX_FRAME];
    logic [47:0]           home_mac;

    vxlan_frame_encapsulator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_byte   (frame_byte),
        .frame_length (frame_length),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last)
    );

    vfe_encap_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_byte   (frame_byte),
        .frame_length (frame_length),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .miscompares  (miscompares),
        .words_owed   (words_owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output stall: alternating runs, mostly short, a few long
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            if (out_stall)
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            else
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
            repeat (run) @(negedge clk);
            out_stall <= ~out_stall;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic [15:0] len, input logic fin,
                             input bit calm, input bit hold);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (hold && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            while (hold && words_owed != 0)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        frame_byte   <= b;
        frame_length <= len;
        frame_end    <= fin;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic fill_frame(input int n, input logic [47:0] smac);
        for (int i = 0; i < n; i++)
            frame_buf[i] = 8'($urandom);
        for (int i = SMAC_FIRST; i <= SMAC_LAST && i < n; i++)
            frame_buf[i] = smac[47 - 8 * (i - SMAC_FIRST) -: 8];
    endtask

    task automatic send_frame(input int n, input logic [15:0] len, input bit jitter,
                              input bit calm, input int hold_at);
        logic [15:0] l;
        for (int i = 0; i < n; i++)
        begin
            l = jitter ? 16'($urandom_range(1, 65499)) : len;
            send_word(frame_buf[i], l, i == n - 1, calm, i == hold_at);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (words_owed != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic setup_reg(input logic [CFG_IDX_W-1:0] idx, input int mode);
        if (mode == CFG_ZEROS)
            write_reg(idx, '0);
        else if (mode == CFG_ONES)
            write_reg(idx, '1);
        else if ($urandom_range(0, 9) < 7)
            write_reg(idx, rand48());
    endtask

    task automatic configure(input int mode);
        setup_reg(REG_SRC_MAC, mode);
        setup_reg(REG_DST_MAC, mode);
        setup_reg(REG_SRC_IP, mode);
        setup_reg(REG_DST_IP, mode);
        setup_reg(REG_UDP_PORT, mode);
        setup_reg(REG_NET_ID, mode);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand48());
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int frames;
        int n;
        int r;
        logic [47:0] smac;
        logic [15:0] len;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_SRC_MAC;
        cfg_data     = '0;
        in_valid     = 1'b0;
        frame_byte   = 8'h00;
        frame_length = 16'd1;
        frame_end    = 1'b0;
        home_mac     = rand48();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // outbound frame under reset settings, one pass-through word
        for (int i = 0; i < 6; i++)
            frame_buf[i] = 8'hff;
        fill_frame(0, home_mac);
        for (int i = SMAC_FIRST; i <= SMAC_LAST; i++)
            frame_buf[i] = home_mac[47 - 8 * (i - SMAC_FIRST) -: 8];
        frame_buf[12] = 8'h00;
        frame_buf[13] = 8'h00;
        frame_buf[14] = 8'h5a;
        send_frame(15, 16'd65499, 1'b0, 1'b0, -1);
        settle();
        configure(CFG_ONES);
        write_reg(REG_SPARE_HI, '0);
        cfg_valid <= 1'b0;

        // one-word frame: return direction, minimum length
        frame_buf[0] = 8'hff;
        send_frame(1, 16'd1, 1'b0, 1'b0, -1);
        settle();
        configure(CFG_ZEROS);

        // short frame cut inside the source MAC
        fill_frame(8, home_mac);
        send_frame(8, 16'h8000, 1'b0, 1'b0, -1);
        settle();
        configure(CFG_RANDOM);

        sent   = 0;
        frames = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (frames % 3 == 2 && $urandom_range(0, 1))
            begin
                settle();
                configure($urandom_range(CFG_ZEROS, CFG_RANDOM));
            end
            r = $urandom_range(0, 99);
            if (r < 25)
                n = $urandom_range(1, 13);
            else if (r < 85)
                n = $urandom_range(14, 22);
            else
                n = $urandom_range(23, 60);
            smac = $urandom_range(0, 1) ? home_mac : rand48();
            fill_frame(n, smac);
            len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65499)) : 16'(n);
            send_frame(n, len, $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                       (frames == 0) ? n - 1 :
                       ($urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : -1);
            sent += n;
            frames++;
        end

        settle();
        repeat (60) @(negedge clk);
        if (miscompares == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
